/* hdl/mvm_pkg.sv */
package mvm_pkg;

    // Fixed field widths
    localparam int VALUE_W   = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 48;
    localparam int ROW_IDX_W = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd1;

    // Item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_MATRIX = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_IDX_W-1:0]    row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    last_row;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     wdata;
    } t_cfg_item;

    // Matrix element handed from the sequencer to the MAC pipeline
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      mac;
        logic                      emit;
        logic                      last;
        logic [ROW_IDX_W-1:0]      row_index;
    } t_issue;

endpackage

/* hdl/mvm_stream_if.sv */
interface mvm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/matrix_vector_multiply.sv */
// Matrix-vector product y = A*x in signed Q3.12, row sums in Q.24 (48 bits).
// Channels: i_item takes items (mode 0 loads the next vector element, mode 1
// is the next matrix element, row by row); o_result gives one transaction per
// finished row (row index, sum, last-row flag); i_cfg writes column_count
// (index 0) and row_count (index 1), always ready; write it only while the
// block idles, which the block does not enforce. Throughput: one item per
// cycle while i_item.ready is high, loads and matrix elements alike. Each
// matrix element does one read of the vector store, one 16x16 multiply and
// one 48-bit add; the store's single registered read port sets that rate.
// Reset: both counts go to 1, all positions and the row sum to zero. The
// vector store is not cleared; each entry must be loaded before it is used.
// Stall: while a result waits on o_result, elements that finish no row keep
// flowing; a second finished row waits in the pipeline and i_item.ready
// drops once the two pipeline stages behind it are full.
module matrix_vector_multiply
    import mvm_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mvm_stream_if.sink   i_item,
    mvm_stream_if.source o_result,
    mvm_stream_if.sink   i_cfg
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    t_in_item                  item;
    t_cfg_item                 cfg;
    t_issue                    issue;
    t_out_item                 res;
    logic                      accept;
    logic                      in_ready;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      res_valid;

    assign item            = i_item.data;
    assign cfg             = i_cfg.data;
    assign i_item.ready    = in_ready;
    assign i_cfg.ready     = 1'b1;
    assign accept          = i_item.valid && in_ready;
    assign o_result.valid  = res_valid;
    assign o_result.data   = res;

    mvm_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .AW          (AW),
        .RW          (RW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (cfg.index),
        .i_cfg_data (cfg.wdata),
        .i_accept   (accept),
        .i_mode     (item.mode),
        .i_value    (item.value),
        .o_issue    (issue),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    mvm_vec_ram #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    mvm_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (issue),
        .i_x        (rd_data),
        .o_in_ready (in_ready),
        .o_valid    (res_valid),
        .o_data     (res),
        .i_ready    (o_result.ready)
    );

endmodule

/* hdl/mvm_vec_ram.sv */
module mvm_vec_ram
    import mvm_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic signed [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    // Vector store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mvm_seq.sv */
module mvm_seq
    import mvm_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024,
    parameter int AW          = 10,
    parameter int RW          = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_accept,
    input  logic                      i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    output t_issue                    o_issue,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic signed [VALUE_W-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr
);

    localparam int KW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int RKW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CFG_W-1:0] r_col_count;
    logic [CFG_W-1:0] r_row_count;
    logic [AW-1:0]    r_load_pos;
    logic [AW-1:0]    r_col_pos;
    logic [RW-1:0]    r_row_pos;

    logic [KW-1:0]    cc;
    logic [AW-1:0]    load_addr;
    logic [KW-1:0]    load_next;
    logic [KW-1:0]    col_next;
    logic [RKW-1:0]   row_next;
    logic             mac;
    logic             emit;
    logic             last;
    logic             is_load;
    logic             is_mat;

    // 0 counts as 1, anything above the maximum counts as the maximum
    function automatic logic [CFG_W-1:0] clamp_count(logic [CFG_W-1:0] v, int unsigned max);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (32'(v) > max) begin
            res = CFG_W'(max);
        end
        return res;
    endfunction

    // Position arithmetic for the item at the input
    always_comb begin
        cc        = KW'(r_col_count);
        load_addr = (KW'(r_load_pos) >= cc) ? '0 : r_load_pos;
        load_next = KW'(load_addr) + KW'(1);
        col_next  = KW'(r_col_pos) + KW'(1);
        mac       = KW'(r_col_pos) < cc;
        emit      = !mac || (col_next >= cc);
        row_next  = RKW'(r_row_pos) + RKW'(1);
        last      = row_next >= RKW'(r_row_count);
        is_load   = i_accept && (i_mode == MODE_LOAD);
        is_mat    = i_accept && (i_mode == MODE_MATRIX);
    end

    // Config registers and positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= CFG_W'(1);
            r_row_count <= CFG_W'(1);
            r_load_pos  <= '0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COLUMN_COUNT: r_col_count <= clamp_count(i_cfg_data, MAX_COLUMNS);
                    REG_ROW_COUNT:    r_row_count <= clamp_count(i_cfg_data, MAX_ROWS);
                    default: ;
                endcase
            end
            if (is_load) begin
                r_load_pos <= (load_next >= cc) ? '0 : load_next[AW-1:0];
            end
            if (is_mat) begin
                if (emit) begin
                    r_col_pos <= '0;
                    r_row_pos <= last ? '0 : row_next[RW-1:0];
                end else begin
                    r_col_pos <= col_next[AW-1:0];
                end
            end
        end
    end

    // Memory access and issue to the MAC pipeline
    always_comb begin
        o_wr_en           = is_load;
        o_wr_addr         = load_addr;
        o_wr_data         = i_value;
        o_rd_en           = is_mat && mac;
        o_rd_addr         = r_col_pos;
        o_issue.valid     = is_mat;
        o_issue.value     = i_value;
        o_issue.mac       = mac;
        o_issue.emit      = emit;
        o_issue.last      = last;
        o_issue.row_index = ROW_IDX_W'(r_row_pos);
    end

endmodule

/* hdl/mvm_mac.sv */
module mvm_mac
    import mvm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_issue                    i_issue,
    input  logic signed [VALUE_W-1:0] i_x,
    output logic                      o_in_ready,
    output logic                      o_valid,
    output t_out_item                 o_data,
    input  logic                      i_ready
);

    t_issue                   r_s1;
    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic                     r_s2_emit;
    logic                     r_s2_last;
    logic [ROW_IDX_W-1:0]     r_s2_row;
    logic signed [SUM_W-1:0]  r_acc;
    logic                     r_o_valid;
    t_out_item                r_o_data;

    logic                     out_free;
    logic                     s2_go;
    logic                     s2_free;
    logic                     s1_free;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [SUM_W-1:0]  n_sum;

    // Stage handshakes: an element that ends no row leaves stage 2 without waiting on the output
    always_comb begin
        out_free   = !r_o_valid || i_ready;
        s2_go      = r_s2_valid && (!r_s2_emit || out_free);
        s2_free    = !r_s2_valid || s2_go;
        s1_free    = !r_s1.valid || s2_free;
        o_in_ready = s1_free;
        // signed 16x16 product; a row end with no MAC adds nothing
        n_prod     = '0;
        if (r_s1.mac) begin
            n_prod = $signed(r_s1.value) * $signed(i_x);
        end
        n_sum      = r_acc + SUM_W'(r_s2_prod);
    end

    // Stage 1: element with the vector entry read out of the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (s1_free) begin
            r_s1 <= i_issue;
        end
    end

    // Stage 2: registered product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_prod <= n_prod;
            r_s2_emit <= r_s1.emit;
            r_s2_last <= r_s1.last;
            r_s2_row  <= r_s1.row_index;
        end
    end

    // Row accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (s2_go) begin
                r_acc <= r_s2_emit ? '0 : n_sum;
            end
            if (s2_go && r_s2_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && r_s2_emit) begin
            r_o_data.row_index <= r_s2_row;
            r_o_data.row_sum   <= n_sum;
            r_o_data.last_row  <= r_s2_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule
